@@ hdl/fpm_pkg.sv @@
// Shared types, constants and character helpers for the fuzzy path match scorer.
// Used by every module in hdl/ except fpm_checker; depends on nothing.
`timescale 1ns / 1ps
package fpm_pkg;

  // Scoring constants
  localparam int HIT_SCORE         = 20;
  localparam int POST_SEP_BONUS    = 4;
  localparam int AFTER_SLASH_BONUS = 6;
  localparam int CAMEL_BONUS       = 2;
  localparam int UPPER_BONUS       = 6;
  localparam int END_PATH_BONUS    = 4;
  localparam int GAP_OPEN_COST     = 16;
  localparam int GAP_EXTEND_COST   = 1;
  localparam int LEAD_BONUS        = 2;
  localparam int SCORE_MAX         = 2047;
  // Upper bound of one cell's match score, used to size score registers
  localparam int CELL_MAX          = 48;

  // Case modes
  localparam logic [1:0] CASE_INSENSITIVE = 2'd0;
  localparam logic [1:0] CASE_SENSITIVE   = 2'd1;
  localparam logic [1:0] CASE_SEMI        = 2'd2;
  localparam logic [1:0] CMP_MODE_RESET   = CASE_SEMI;

  // Register indexes
  localparam logic CFG_CMP_MODE = 1'b0;

  localparam logic [7:0] CH_SLASH = 8'h2F;

  // Command classes produced by the front end
  typedef enum logic [1:0] {
    OP_QUERY,
    OP_STRING,
    OP_SCORE
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
    logic       gap_ok;
    logic       lead_gap;
    logic       first;
  } cmd_t;

  typedef struct packed {
    logic        matched;
    logic [11:0] score;
    logic [7:0]  end_pos;
  } result_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    B_IDLE,
    B_INIT,
    B_ROW_RD,
    B_ROW_WT,
    B_CELL_RD,
    B_CELL_EX,
    B_DONE
  } bstate_t;

  function automatic logic is_low(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic is_up(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic [7:0] to_low(input logic [7:0] c);
    return is_up(c) ? (c + 8'd32) : c;
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return (c == 8'h2F) || (c == 8'h5F) || (c == 8'h2D) || (c == 8'h2E) ||
           (c == 8'h23) || (c == 8'h5C) || (c == 8'h20);
  endfunction

  function automatic logic chars_match(input logic [7:0] s, input logic [7:0] q,
                                       input logic [1:0] mode);
    logic res;
    if (to_low(s) != to_low(q)) res = 1'b0;
    else if (mode == CASE_INSENSITIVE) res = 1'b1;
    else if (mode == CASE_SENSITIVE) res = (s == q);
    else res = is_low(q) || (s == q);
    return res;
  endfunction

endpackage

@@ hdl/fpm_front.sv @@
// Front end: takes input transactions, classifies them and queues commands.
// Depends on fpm_pkg.
`timescale 1ns / 1ps
module fpm_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic          func,
  input  logic [7:0]    ch,
  input  logic          gap_ok,
  input  logic          lead_gap,
  input  logic          first,
  input  logic          last,
  output logic          cmd_valid,
  output fpm_pkg::cmd_t cmd,
  input  logic          cmd_pop
);
  import fpm_pkg::*;

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       cmd_in;

  // Classify: last only matters on string characters
  always_comb begin
    cmd_in.op       = (func == 1'b0) ? OP_QUERY : (last ? OP_SCORE : OP_STRING);
    cmd_in.ch       = ch;
    cmd_in.gap_ok   = gap_ok;
    cmd_in.lead_gap = lead_gap;
    cmd_in.first    = first;
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slot[rd_ptr];

  // Two-entry command queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop && cmd_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push && !full} - {1'b0, cmd_pop && cmd_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot[wr_ptr] <= cmd_in;
    end
  end

endmodule

@@ hdl/fpm_resq.sv @@
// Result queue: two entries between the scoring engine and the result port.
// Depends on fpm_pkg.
`timescale 1ns / 1ps
module fpm_resq (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_push,
  input  fpm_pkg::result_t res_in,
  output logic             res_full,
  output logic             empty,
  input  logic             pop,
  output fpm_pkg::result_t res_out
);
  import fpm_pkg::*;

  result_t    slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign res_out  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (res_push && !res_full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, res_push && !res_full} - {1'b0, pop && !empty};
    end
  end

  always_ff @(posedge clk) begin
    if (res_push && !res_full) begin
      slot[wr_ptr] <= res_in;
    end
  end

endmodule

@@ hdl/fpm_back.sv @@
// Back end: query and string storage, position bonus and the banded score DP.
// Depends on fpm_pkg.
`timescale 1ns / 1ps
module fpm_back #(
  parameter int MAX_STRING = 256,
  parameter int MAX_QUERY  = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       cmp_mode,
  input  logic             cmd_valid,
  input  fpm_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  output logic             res_push,
  output fpm_pkg::result_t res,
  input  logic             res_full
);
  import fpm_pkg::*;

  localparam int QLW = $clog2(MAX_QUERY + 1);
  localparam int SLW = $clog2(MAX_STRING + 1);
  localparam int QAW = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
  localparam int SAW = $clog2(MAX_STRING);
  localparam int CW  = ((SLW > QLW) ? SLW : QLW) + 1;
  localparam int SW  = $clog2(MAX_QUERY * CELL_MAX + 1) + 2;

  localparam logic signed [SW-1:0] NEG1 = -1;
  localparam logic signed [SW-1:0] ZERO = '0;
  localparam logic signed [SW-1:0] GP   = SW'(GAP_EXTEND_COST);
  localparam logic signed [SW-1:0] FGP  = SW'(GAP_OPEN_COST);

  bstate_t state, state_next;

  // Memories
  logic [8:0]      qmem [MAX_QUERY];
  logic [7:0]      smem [MAX_STRING];
  logic [2*SW-1:0] rmem [MAX_QUERY+1];
  logic [MAX_QUERY:0] rvld;

  // Loaded lengths and string facts
  logic [QLW-1:0] qlen;
  logic           lead;
  logic [SLW-1:0] slen;
  logic           ls_valid;
  logic [SAW-1:0] ls_idx;

  // DP loop state
  logic [SLW-1:0]        i;
  logic [QLW-1:0]        j;
  logic [QLW-1:0]        jlo;
  logic signed [SW-1:0]  best;
  logic [SLW-1:0]        best_i;
  logic [7:0]            cur_ch;
  logic [7:0]            prev_ch;
  logic [3:0]            bonus;
  logic signed [SW-1:0]  top_m;
  logic signed [SW-1:0]  top_g;

  // Registered memory read data
  logic [8:0]      qrd;
  logic [7:0]      srd;
  logic [2*SW-1:0] rrd;
  logic            rvld_rd;

  // Load path signals
  logic [QLW-1:0] qaddr;
  logic           q_we;
  logic [SLW-1:0] saddr;
  logic           s_we;
  logic           accept;

  // Loop signals
  logic [SLW-1:0] im1;
  logic [QLW-1:0] jm1;
  logic [CW-1:0]  i_c, q_c, n_c, span_c, jhi_c, jlo_c;
  logic [QLW-1:0] r_addr;
  logic           r_re;
  logic [3:0]     bonus_c;
  logic           first_row;

  // Cell signals
  logic signed [SW-1:0] left_m, left_g, g_c, m_c, a1, a2, t_c, ms_c;
  logic                 mt;
  logic [6:0]           msu;
  logic                 gflag;
  logic [7:0]           qch;
  logic signed [31:0]   best32;
  logic [SLW+7:0]       bi_ext;

  assign accept = (state == B_IDLE) && cmd_valid;

  // Load addresses
  always_comb begin
    qaddr = cmd.first ? '0 : qlen;
    saddr = cmd.first ? '0 : slen;
    q_we  = accept && (cmd.op == OP_QUERY) && (qaddr < QLW'(MAX_QUERY));
    s_we  = accept && (cmd.op != OP_QUERY) && (saddr < SLW'(MAX_STRING));
  end

  // Band limits of the current row
  always_comb begin
    im1    = i - 1'b1;
    jm1    = j - 1'b1;
    i_c    = CW'(i);
    q_c    = CW'(qlen);
    n_c    = CW'(slen);
    span_c = n_c - q_c;
    jhi_c  = (q_c < i_c) ? q_c : i_c;
    jlo_c  = (i_c > span_c) ? (i_c - span_c) : CW'(1);
    r_re   = (state == B_ROW_RD) || (state == B_CELL_RD);
    r_addr = (state == B_ROW_RD) ? QLW'(jhi_c) : jm1;
  end

  // Position bonus of the current string character
  always_comb begin
    first_row = (i == SLW'(1));
    bonus_c   = 4'd0;
    if (!first_row && is_low(prev_ch) && is_up(srd)) begin
      bonus_c = bonus_c + 4'(CAMEL_BONUS);
    end
    if (!is_sep(srd) && (first_row || is_sep(prev_ch))) begin
      bonus_c = bonus_c + ((!first_row && (prev_ch == CH_SLASH)) ?
                           4'(AFTER_SLASH_BONUS) : 4'(POST_SEP_BONUS));
    end
    if (ls_valid && (ls_idx != '0) && (im1 > SLW'(ls_idx))) begin
      bonus_c = bonus_c + 4'(END_PATH_BONUS);
    end
  end

  // One DP cell
  always_comb begin
    qch    = qrd[7:0];
    gflag  = qrd[8];
    left_m = (j == QLW'(1)) ? ZERO : (rvld_rd ? signed'(rrd[2*SW-1:SW]) : NEG1);
    left_g = (j == QLW'(1)) ? ZERO : (rvld_rd ? signed'(rrd[SW-1:0]) : NEG1);
    // gap score
    a1  = top_g - GP;
    a2  = top_m - FGP;
    g_c = NEG1;
    if (gflag) begin
      g_c = (a1 > a2) ? a1 : a2;
      if (g_c < NEG1) g_c = NEG1;
      if (((top_g != NEG1) || (top_m != NEG1)) && (g_c == NEG1)) g_c = ZERO;
    end
    // match score
    mt  = chars_match(cur_ch, qch, cmp_mode);
    msu = 7'(HIT_SCORE) + {3'b000, bonus};
    if (is_up(cur_ch) && (qch == cur_ch)) msu = msu + 7'(UPPER_BONUS);
    if ((j == QLW'(1)) && (bonus != 4'd0)) msu = msu + 7'(LEAD_BONUS);
    ms_c = signed'(SW'(msu));
    t_c  = (left_g > left_m) ? left_g : left_m;
    m_c  = NEG1;
    if (mt && ((j > QLW'(1)) || first_row || lead) && (t_c >= ZERO)) begin
      m_c = t_c + ms_c;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (accept && (cmd.op == OP_SCORE)) state_next = B_INIT;
      end
      B_INIT: begin
        if ((qlen != '0) && (CW'(slen) >= CW'(qlen))) state_next = B_ROW_RD;
        else state_next = B_DONE;
      end
      B_ROW_RD:  state_next = B_ROW_WT;
      B_ROW_WT:  state_next = B_CELL_RD;
      B_CELL_RD: state_next = B_CELL_EX;
      B_CELL_EX: begin
        if (j == jlo) state_next = (i == slen) ? B_DONE : B_ROW_RD;
        else state_next = B_CELL_RD;
      end
      B_DONE: begin
        if (!res_full) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_pop  = accept;
    res_push = (state == B_DONE) && !res_full;
    best32   = 32'(best);
    bi_ext   = {8'd0, best_i - 1'b1};
    if (best > NEG1) begin
      res.matched = 1'b1;
      res.score   = (best32 > SCORE_MAX) ? 12'(SCORE_MAX) : best32[11:0];
      res.end_pos = bi_ext[7:0];
    end else begin
      res.matched = 1'b0;
      res.score   = '1;
      res.end_pos = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else state <= state_next;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      qlen     <= '0;
      lead     <= 1'b0;
      slen     <= '0;
      ls_valid <= 1'b0;
      rvld     <= '0;
    end else begin
      if (accept && (cmd.op == OP_QUERY)) begin
        if (cmd.first) begin
          lead <= cmd.lead_gap;
          qlen <= '0;
        end
        if (q_we) qlen <= qaddr + 1'b1;
      end
      if (accept && (cmd.op != OP_QUERY)) begin
        if (cmd.first) begin
          slen     <= '0;
          ls_valid <= 1'b0;
        end
        if (s_we) begin
          slen <= saddr + 1'b1;
          if (cmd.ch == CH_SLASH) ls_valid <= 1'b1;
        end
      end
      if (state == B_INIT) rvld <= '0;
      if (state == B_CELL_EX) rvld[j] <= 1'b1;
    end
  end

  // DP datapath registers
  always_ff @(posedge clk) begin
    if (s_we && (cmd.ch == CH_SLASH)) ls_idx <= saddr[SAW-1:0];
    unique case (state)
      B_INIT: begin
        best    <= NEG1;
        best_i  <= '0;
        i       <= SLW'(1);
        prev_ch <= 8'd0;
      end
      B_ROW_RD: begin
        j   <= QLW'(jhi_c);
        jlo <= QLW'(jlo_c);
      end
      B_ROW_WT: begin
        bonus   <= bonus_c;
        cur_ch  <= srd;
        prev_ch <= srd;
        top_m   <= rvld_rd ? signed'(rrd[2*SW-1:SW]) : NEG1;
        top_g   <= rvld_rd ? signed'(rrd[SW-1:0]) : NEG1;
      end
      B_CELL_EX: begin
        top_m <= left_m;
        top_g <= left_g;
        j     <= jm1;
        if ((j == qlen) && (gflag || (i == slen)) && (m_c >= best)) begin
          best   <= m_c;
          best_i <= i;
        end
        if ((j == jlo) && (i != slen)) i <= i + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (q_we) qmem[qaddr[QAW-1:0]] <= {cmd.gap_ok, cmd.ch};
    if (state == B_CELL_RD) qrd <= qmem[jm1[QAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (s_we) smem[saddr[SAW-1:0]] <= cmd.ch;
    if (state == B_ROW_RD) srd <= smem[im1[SAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state == B_CELL_EX) rmem[j] <= {m_c, g_c};
    if (r_re) begin
      rrd     <= rmem[r_addr];
      rvld_rd <= rvld[r_addr];
    end
  end

endmodule

@@ hdl/fuzzy_path_match_scorer.sv @@
// Fuzzy path match scorer, top level: configuration register and the three parts.
// Depends on fpm_pkg, fpm_front, fpm_back and fpm_resq.
`timescale 1ns / 1ps
// Load a query one character per transaction (func 0), then a candidate string
// (func 1); the string character marked last starts scoring and yields one result
// (matched, score, end_pos). Query and plain string characters are taken by the
// scoring engine while it is idle; a two-entry command queue in front of it absorbs
// bursts. Scoring an n-character string against a q-character query walks the band
// row by row: for each string position the engine fetches the character and forms
// its bonus (B_ROW_RD, B_ROW_WT), then visits each DP cell of the band in a read and
// an execute state (B_CELL_RD, B_CELL_EX), because the score row lives in a
// single-port memory with registered reads. Results wait in a two-entry queue, so the next
// commands are taken while a result is not yet popped. The compare-mode
// register sits at byte 0.
module fuzzy_path_match_scorer #(
  parameter int MAX_STRING = 256,
  parameter int MAX_QUERY  = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               func,
  input  logic [7:0]         ch,
  input  logic               gap_ok,
  input  logic               lead_gap,
  input  logic               first,
  input  logic               last,
  output logic               empty,
  input  logic               pop,
  output logic               matched,
  output logic signed [11:0] score,
  output logic [7:0]         end_pos,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import fpm_pkg::*;

  logic [1:0] cmp_mode_r;
  logic       cfg_sel;
  cmd_t       cmd;
  logic       cmd_valid;
  logic       cmd_pop;
  result_t    res_in;
  result_t    res_out;
  logic       res_push;
  logic       res_full;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_sel = (paddr[2] == CFG_CMP_MODE);
  assign prdata  = cfg_sel ? {30'd0, cmp_mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_mode_r <= CMP_MODE_RESET;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      cmp_mode_r <= pwdata[1:0];
    end
  end

  fpm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .func      (func),
    .ch        (ch),
    .gap_ok    (gap_ok),
    .lead_gap  (lead_gap),
    .first     (first),
    .last      (last),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  fpm_back #(
    .MAX_STRING (MAX_STRING),
    .MAX_QUERY  (MAX_QUERY)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmp_mode  (cmp_mode_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res       (res_in),
    .res_full  (res_full)
  );

  fpm_resq u_resq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res_in   (res_in),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .res_out  (res_out)
  );

  assign matched = res_out.matched;
  assign score   = signed'(res_out.score);
  assign end_pos = res_out.end_pos;

endmodule

@@ hdl/fpm_checker.sv @@
// Port-level checks for the fuzzy path match scorer, bound to the top level.
// Depends on fuzzy_path_match_scorer.
`timescale 1ns / 1ps
module fpm_checker (
  input logic               clk,
  input logic               rst,
  input logic               empty,
  input logic               pop,
  input logic               matched,
  input logic signed [11:0] score,
  input logic [7:0]         end_pos,
  input logic               pready
);

  // Result queue comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // A waiting result holds until popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(matched) && $stable(score) &&
                          $stable(end_pos)))
    else $error("waiting result changed before pop");

  // A miss reports score -1 and position 0
  a_miss: assert property (@(posedge clk) disable iff (rst)
    (!empty && !matched) |-> ((score == -12'sd1) && (end_pos == 8'd0)))
    else $error("unmatched result with bad score or position");

  // A hit never reports a negative score
  a_hit: assert property (@(posedge clk) disable iff (rst)
    (!empty && matched) |-> (score[11] == 1'b0))
    else $error("matched result with negative score");

  // Configuration port never stalls
  a_ready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind fuzzy_path_match_scorer fpm_checker u_fpm_checker (
  .clk     (clk),
  .rst     (rst),
  .empty   (empty),
  .pop     (pop),
  .matched (matched),
  .score   (score),
  .end_pos (end_pos),
  .pready  (pready)
);

@@ dv/tb_fuzzy_path_match_scorer.sv @@
// Self-checking testbench for fuzzy_path_match_scorer: directed table, then random
// query/string sequences under every compare mode, checked against a local model.
// Depends on fpm_pkg and the RTL in hdl/.
`timescale 1ns / 1ps
module tb_fuzzy_path_match_scorer;
  import fpm_pkg::*;

  localparam int QMAX        = 32;
  localparam int SMAX        = 256;
  localparam int LIMIT       = 1000000;
  localparam int PHASE_ITEMS = 25;
  localparam int SETTLE      = 40;
  localparam logic FN_QUERY  = 1'b0;
  localparam logic FN_STRING = 1'b1;
  localparam logic [1:0] CASE_SPARE    = 2'd3;
  localparam logic [2:0] ADDR_CMP_MODE = 3'd0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0, full;
  logic func = 1'b0, gap_ok = 1'b0, lead_gap = 1'b0, first = 1'b0, last = 1'b0;
  logic [7:0] ch = 8'h00;
  logic empty, pop = 1'b0, matched;
  logic signed [11:0] score;
  logic [7:0] end_pos;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0, pready;
  logic [2:0] paddr = 3'd0;
  logic [31:0] pwdata = 32'd0, prdata;

  fuzzy_path_match_scorer dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .func(func), .ch(ch),
    .gap_ok(gap_ok), .lead_gap(lead_gap), .first(first), .last(last),
    .empty(empty), .pop(pop), .matched(matched), .score(score), .end_pos(end_pos),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Scoring model state
  logic [7:0] qry_chr [QMAX];
  logic       qry_gap [QMAX];
  logic       qry_lead = 1'b0;
  int         qry_len = 0;
  logic [7:0] str_chr [SMAX];
  int         str_len = 0;
  int         pos_bonus [SMAX];
  int         m_row [QMAX+1];
  int         g_row [QMAX+1];
  logic [1:0] mode_now = CMP_MODE_RESET;

  result_t score_q[$];
  int errors = 0;
  int cycles = 0;
  int sent = 0;
  bit quiet = 0;
  bit hold_req = 0;

  function automatic bit lc(logic [7:0] c);
    return c >= "a" && c <= "z";
  endfunction
  function automatic bit uc(logic [7:0] c);
    return c >= "A" && c <= "Z";
  endfunction
  function automatic logic [7:0] fold(logic [7:0] c);
    return uc(c) ? c + 8'd32 : c;
  endfunction
  function automatic bit sepc(logic [7:0] c);
    return c == "/" || c == "_" || c == "-" || c == "." || c == "#" ||
           c == 8'h5C || c == " ";
  endfunction

  function automatic bit same_char(logic [7:0] s, logic [7:0] q);
    if (fold(s) != fold(q)) return 0;
    if (mode_now == CASE_INSENSITIVE) return 1;
    if (mode_now == CASE_SENSITIVE) return s == q;
    return lc(q) || s == q;
  endfunction

  function automatic bit gap_here(int j);
    return j == 0 ? qry_lead : qry_gap[j-1];
  endfunction

  function automatic int imax(int a, int b);
    return a > b ? a : b;
  endfunction

  // Banded DP over the loaded string; returns the best alignment
  function automatic result_t score_string();
    result_t r;
    int n, q, best, best_i, lslash, b, jhi, jlo, tg, tm, lg, lm, g, m, ms;
    bit psep, sp;
    logic [7:0] c, s, qc;
    n = str_len; q = qry_len; best = -1; best_i = 0;
    for (int j = 0; j <= QMAX; j++) begin m_row[j] = -1; g_row[j] = -1; end
    if (q > 0 && n >= q) begin
      lslash = -1; psep = 1;
      for (int i = 0; i < n; i++) begin
        c = str_chr[i]; sp = sepc(c); b = 0;
        if (i > 0 && lc(str_chr[i-1]) && uc(c)) b += CAMEL_BONUS;
        if (sp) begin
          if (c == "/") lslash = i;
        end else if (psep) begin
          if (i > 0 && str_chr[i-1] == "/") b += AFTER_SLASH_BONUS;
          else b += POST_SEP_BONUS;
        end
        pos_bonus[i] = b; psep = sp;
      end
      if (lslash > 0)
        for (int i = lslash + 1; i < n; i++) pos_bonus[i] += END_PATH_BONUS;
      for (int i = 1; i <= n; i++) begin
        jhi = q < i ? q : i;
        jlo = (i > n - q) ? i - (n - q) : 1;
        for (int j = jhi; j >= jlo && j >= 1; j--) begin
          tg = g_row[j]; tm = m_row[j];
          lg = j > 1 ? g_row[j-1] : 0;
          lm = j > 1 ? m_row[j-1] : 0;
          g = -1; m = -1;
          if (gap_here(j)) begin
            g = imax(imax(tg - GAP_EXTEND_COST, tm - GAP_OPEN_COST), -1);
            if ((tg != -1 || tm != -1) && g == -1) g = 0;
          end
          qc = qry_chr[j-1]; s = str_chr[i-1];
          if (!same_char(s, qc)) ms = -1;
          else begin
            ms = HIT_SCORE + pos_bonus[i-1];
            if (uc(s) && qc == s) ms += UPPER_BONUS;
            if (j == 1 && pos_bonus[i-1] > 0) ms += LEAD_BONUS;
          end
          if (ms > 0 && (j > 1 || i == 1 || gap_here(0)))
            if (imax(lg, lm) >= 0) m = imax(lg, lm) + ms;
          g_row[j] = g; m_row[j] = m;
        end
        if (i >= q && m_row[q] >= best && (gap_here(q) || i == n)) begin
          best = m_row[q]; best_i = i;
        end
      end
    end
    if (best > -1) begin
      r.matched = 1'b1;
      r.score = (best > SCORE_MAX) ? 12'(SCORE_MAX) : 12'(best);
      r.end_pos = 8'(best_i - 1);
    end else begin
      r.matched = 1'b0; r.score = 12'hFFF; r.end_pos = 8'd0;
    end
    return r;
  endfunction

  // Update model state with one accepted transaction; 1 when a result is due
  function automatic bit absorb(logic f, logic [7:0] c, logic g, logic ld, logic fs,
                                logic ls, output result_t r);
    r = '0;
    if (f == FN_QUERY) begin
      if (fs) begin qry_len = 0; qry_lead = ld; end
      if (qry_len < QMAX) begin
        qry_chr[qry_len] = c; qry_gap[qry_len] = g; qry_len++;
      end
      return 0;
    end
    if (fs) str_len = 0;
    if (str_len < SMAX) begin str_chr[str_len] = c; str_len++; end
    if (!ls) return 0;
    r = score_string();
    return 1;
  endfunction

  // Offer one transaction, with an optional random gap in front
  task automatic send(logic f, logic [7:0] c, logic g, logic ld, logic fs, logic ls,
                      bit typed = 0, result_t tr = '0);
    result_t r;
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 8);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    func <= f; ch <= c; gap_ok <= g; lead_gap <= ld; first <= fs; last <= ls;
    push <= 1'b1;
    do @(posedge clk); while (full);
    sent++;
    if (absorb(f, c, g, ld, fs, ls, r)) score_q.push_back(typed ? tr : r);
  endtask

  // Drain outstanding results, then let trailing commands settle
  task automatic drain();
    push <= 1'b0;
    wait (score_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] a, logic [31:0] d);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    mode_now = d[1:0];
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 15))
      0: return "/";
      1: return "_";
      2: return ".";
      3: return "-";
      4: return " ";
      5: return 8'h5C;
      6: return "#";
      7: return 8'($urandom_range(0, 255));
      8, 9: return "A" + 8'($urandom_range(0, 3));
      default: return "a" + 8'($urandom_range(0, 3));
    endcase
  endfunction

  // One well-formed query followed by a few strings, with occasional noise
  task automatic random_burst(int qmax_len, int smax_len, int n_str);
    int ql, sl;
    logic [7:0] qs [QMAX+4];
    ql = $urandom_range(1, qmax_len);
    for (int k = 0; k < ql; k++) begin
      qs[k % (QMAX+4)] = pick_char();
      send(FN_QUERY, qs[k % (QMAX+4)], $urandom_range(0, 3) != 0,
           1'($urandom_range(0, 1)), k == 0, $urandom_range(0, 7) == 0);
    end
    for (int s = 0; s < n_str; s++) begin
      sl = $urandom_range(1, smax_len);
      for (int k = 0; k < sl; k++) begin
        if (ql <= QMAX + 4 && $urandom_range(0, 2) == 0)
          send(FN_STRING, qs[$urandom_range(0, (ql < QMAX+4 ? ql : QMAX+4) - 1)],
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               k == 0 && $urandom_range(0, 9) != 0, k == sl - 1);
        else
          send(FN_STRING, pick_char(), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)),
               k == 0 && $urandom_range(0, 9) != 0, k == sl - 1);
      end
      if ($urandom_range(0, 9) == 0)
        send(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  typedef struct {
    logic f; logic [7:0] c; logic g, ld, fs, ls;
    bit typed; result_t r;
  } row_t;

  localparam result_t NOMATCH = '{matched: 1'b0, score: 12'hFFF, end_pos: 8'd0};

  // Directed rows: typed results for empty query and short string
  row_t rows [] = '{
    '{FN_STRING, "a",   0, 0, 1, 1, 1, NOMATCH},
    '{FN_QUERY,  "a",   1, 1, 1, 0, 0, '0},
    '{FN_QUERY,  "b",   1, 0, 0, 1, 0, '0},
    '{FN_STRING, "a",   1, 1, 1, 1, 1, NOMATCH},
    '{FN_STRING, "x",   0, 0, 1, 0, 0, '0},
    '{FN_STRING, "a",   0, 0, 0, 0, 0, '0},
    '{FN_STRING, "/",   0, 0, 0, 0, 0, '0},
    '{FN_STRING, "B",   0, 0, 0, 1, 0, '0},
    '{FN_QUERY,  8'hFF, 0, 0, 1, 0, 0, '0},
    '{FN_STRING, 8'h00, 0, 0, 1, 0, 0, '0},
    '{FN_STRING, 8'hFF, 0, 0, 0, 1, 0, '0},
    '{FN_STRING, 8'hFF, 0, 0, 1, 1, 0, '0},
    '{FN_QUERY,  "f",   1, 1, 1, 0, 0, '0},
    '{FN_QUERY,  "O",   1, 0, 0, 0, 0, '0},
    '{FN_QUERY,  "o",   0, 1, 0, 0, 0, '0},
    '{FN_STRING, "s",   0, 0, 1, 0, 0, '0},
    '{FN_STRING, "/",   0, 0, 0, 0, 0, '0},
    '{FN_STRING, "F",   0, 0, 0, 0, 0, '0},
    '{FN_STRING, "o",   0, 0, 0, 0, 0, '0},
    '{FN_STRING, "O",   0, 0, 0, 0, 0, '0},
    '{FN_STRING, "_",   0, 0, 0, 0, 0, '0},
    '{FN_STRING, "o",   0, 0, 0, 1, 0, '0},
    '{FN_STRING, 8'hC8, 1, 1, 1, 1, 0, '0}
  };

  // Result checker with random and long stalls
  initial begin
    int burst;
    result_t e;
    burst = 0;
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end else begin
        if (!quiet && burst == 0 && $urandom_range(0, 5) == 0) burst = $urandom_range(1, 8);
        if (!quiet && burst > 0) begin
          pop <= 1'b0; burst--;
        end else pop <= 1'b1;
        @(posedge clk);
        if (pop && !empty) begin
          if (score_q.size() == 0) begin
            $error("unexpected result transaction");
            errors++;
          end else begin
            e = score_q.pop_front();
            if (matched !== e.matched) begin
              $error("matched exp %0d got %0d", e.matched, matched); errors++;
            end
            if (score !== $signed(e.score)) begin
              $error("score exp %0d got %0d", $signed(e.score), score); errors++;
            end
            if (end_pos !== e.end_pos) begin
              $error("end_pos exp %0d got %0d", e.end_pos, end_pos); errors++;
            end
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Main sequence
  initial begin
    logic [1:0] modes [5];
    int base;
    modes = '{CASE_SEMI, CASE_INSENSITIVE, CASE_SENSITIVE, CASE_SPARE, CASE_SEMI};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[k])
      send(rows[k].f, rows[k].c, rows[k].g, rows[k].ld, rows[k].fs, rows[k].ls,
           rows[k].typed, rows[k].r);
    drain();
    for (int p = 0; p < 5; p++) begin
      reg_write(ADDR_CMP_MODE, {30'd0, modes[p]});
      base = sent;
      if (p == 4) quiet = 1;
      if (p == 1) begin
        // receiver stalls long while short strings pile up
        hold_req = 1;
        for (int k = 0; k < 30; k++) send(FN_STRING, pick_char(), 0, 0, 1, 1);
      end
      if (p == 2) begin
        // overlong query and string
        random_burst(QMAX + 3, 2, 1);
        send(FN_QUERY, "a", 1, 1, 1, 0);
        for (int m = 0; m < 33; m++) send(FN_QUERY, pick_char(), 1, 0, 0, 0);
        for (int m = 0; m < 260; m++) send(FN_STRING, pick_char(), 0, 0, m == 0, m == 259);
      end
      while (sent < base + PHASE_ITEMS) random_burst(6, 14, $urandom_range(1, 4));
      drain();
    end
    drain();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

@@ files.f @@
hdl/fpm_pkg.sv
hdl/fpm_front.sv
hdl/fpm_resq.sv
hdl/fpm_back.sv
hdl/fuzzy_path_match_scorer.sv
hdl/fpm_checker.sv
dv/tb_fuzzy_path_match_scorer.sv
